/* hw/rtl/wmm_pkg.sv */
// Shared types and constants of the min/max waveform plotter.
`timescale 1ns / 1ps
`default_nettype none
package wmm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COORD_W     = 14;
  localparam int REG_W       = 12;
  localparam int REG_IDX_W   = 2;
  localparam int GEO_W       = 15;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_USER_W  = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_SAMPLES_DEF = 4096;

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd3;

  localparam logic [REG_W-1:0] LEFT_RST   = 12'd0;
  localparam logic [REG_W-1:0] TOP_RST    = 12'd0;
  localparam logic [REG_W-1:0] RIGHT_RST  = 12'd640;
  localparam logic [REG_W-1:0] BOTTOM_RST = 12'd480;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
  } wmm_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pen;
    logic               done;
    logic               empty;
  } wmm_res_t;

endpackage
`default_nettype wire

/* hw/rtl/wmm_front.sv */
// Front end: accepts input transactions, classifies them and queues them in order.
`timescale 1ns / 1ps
`default_nettype none
module wmm_front #(
  parameter int DEPTH = wmm_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [wmm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             in_tuser,
  output logic                                  q_valid,
  output wmm_pkg::wmm_item_t                    q_item,
  input  wire logic                             q_pop
);
  import wmm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  wmm_item_t        fifo_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [FW-1:0]    fill_r;
  logic             push;
  wmm_item_t        item;

  assign in_tready = (fill_r != FW'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != '0);
  assign q_item    = fifo_r[rd_ptr_r];

  always_comb begin
    item.kind   = in_tuser ? KIND_FETCH : KIND_LOAD;
    item.first  = in_tdata[SAMPLE_W];
    item.sample = $signed(in_tdata[SAMPLE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (!push && q_pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wmm_div.sv */
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module wmm_div #(
  parameter int NW = 36,
  parameter int DW = 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0]        den,
  output logic                      busy,
  output logic                      done,
  output logic signed [NW-1:0]      quo
);
  localparam int SW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r;
  logic          neg_r;
  logic [SW-1:0] step_r;
  logic          busy_r, done_r;
  logic [DW:0]   sh, diff;
  logic          fit;

  assign sh   = {rem_r, q_r[NW-1]};
  assign diff = sh - {1'b0, den_r};
  assign fit  = (sh >= {1'b0, den_r});
  assign busy = busy_r;
  assign done = done_r;
  assign quo  = $signed(neg_r ? (~q_r + 1'b1) : q_r);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[NW-1] ? (~num + 1'b1) : num;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NW-1];
    end else if (busy_r) begin
      rem_r <= fit ? diff[DW-1:0] : sh[DW-1:0];
      q_r   <= {q_r[NW-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(NW);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wmm_back.sv */
// Back end: sample store, record extremes, drawing sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module wmm_back #(
  parameter int MAX_SAMPLES = wmm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wmm_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  wire logic [wmm_pkg::REG_W-1:0]         cfg_wdata,
  input  wire logic                              q_valid,
  input  wmm_pkg::wmm_item_t                     q_item,
  output logic                                   q_pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [wmm_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tlast,
  output logic [wmm_pkg::OUT_USER_W-1:0]         out_tuser
);
  import wmm_pkg::*;

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int MA  = (CW + 2 > 18) ? CW + 2 : 18;
  localparam int MB  = (CW + 1 > GEO_W) ? CW + 1 : GEO_W;
  localparam int PRW = MA + MB;
  localparam int NW  = PRW + 2;
  localparam int DW  = (CW + 2 > 19) ? CW + 2 : 19;
  localparam int BW  = DW - 1;
  localparam int XW  = (CW + 2 > GEO_W + 1) ? CW + 2 : GEO_W + 1;
  localparam int LW  = 20;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHK   = 4'd1;
  localparam logic [3:0] ST_PREAD = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_DIVS  = 4'd4;
  localparam logic [3:0] ST_DIVW  = 4'd5;
  localparam logic [3:0] ST_SCAN  = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;

  localparam logic [2:0] OP_JF = 3'd0;
  localparam logic [2:0] OP_JN = 3'd1;
  localparam logic [2:0] OP_L1 = 3'd2;
  localparam logic [2:0] OP_L2 = 3'd3;
  localparam logic [2:0] OP_PL = 3'd4;
  localparam logic [2:0] OP_PX = 3'd5;

  logic [REG_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [3:0]       state_r;
  logic [2:0]       op_r;
  logic [CW-1:0]    cnt_r, col_r, jb_r, jf_r, pt_r, j_r;
  logic signed [SAMPLE_W-1:0] min_r, lo_r, hi_r, rdata_r;
  logic signed [SAMPLE_W:0]   max_r;
  logic             phase_r, fin_r, issue_r, rd_vld_r, scan_first_r;
  logic signed [MA-1:0]  mul_a_r;
  logic signed [MB-1:0]  mul_b_r;
  logic [BW-1:0]         den_b_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [LW-1:0]  l1_r;
  wmm_res_t              res_r, out_r;
  logic                  out_vld_r;

  logic signed [SAMPLE_W-1:0] sample_mem [MAX_SAMPLES];

  logic signed [GEO_W-1:0] x0, ybase, dy, wd;
  logic signed [XW-1:0]    w_x, m_x, c_x, cn_x;
  logic                    bmode, w_pos;
  logic signed [SAMPLE_W+1:0] rng;
  logic [BW-1:0]           rng_b;
  logic [CW-1:0]           cn1, cnt_eff;
  logic [CW:0]             cn2;
  logic                    rd_en, mem_we, out_free, div_start, div_busy, div_done;
  logic [AW-1:0]           rd_addr;
  logic signed [NW-1:0]    div_num, div_q, m_n;
  logic [DW-1:0]           div_den;
  logic signed [LW-1:0]    q_l, l2;
  logic                    pt_last;

  assign x0    = $signed({3'b000, left_r}) + 15'sd5;
  assign ybase = $signed({3'b000, bottom_r}) - 15'sd5;
  assign dy    = $signed({3'b000, bottom_r}) - $signed({3'b000, top_r}) - 15'sd10;
  assign wd    = $signed({3'b000, right_r}) - $signed({3'b000, left_r}) - 15'sd10;
  assign w_x   = XW'(wd);
  assign m_x   = $signed(XW'(cnt_r));
  assign c_x   = $signed(XW'(col_r));
  assign cn1   = col_r + 1'b1;
  assign cn2   = {1'b0, cn1} + 1'b1;
  assign cn_x  = $signed(XW'(cn1));
  assign bmode = (w_x < m_x);
  assign w_pos = (wd > 15'sd0);
  assign rng   = (SAMPLE_W + 2)'(max_r) - (SAMPLE_W + 2)'(min_r);
  // The range is kept at least one so that the height divide is always defined.
  assign rng_b = (rng < 18'sd1) ? BW'(1) : BW'($unsigned(rng));
  assign cnt_eff = q_item.first ? '0 : cnt_r;
  assign m_n   = $signed(NW'(cnt_r));
  assign q_l   = LW'(div_q);
  assign l2    = (q_l <= l1_r) ? l1_r + 1'b1 : q_l;
  assign pt_last = ((pt_r + 1'b1) == cnt_r);

  assign out_free  = !out_vld_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign mem_we    = q_pop && (q_item.kind == KIND_LOAD) && (cnt_eff < MAX_CNT);
  assign div_start = (state_r == ST_DIVS);
  assign div_num   = {prod_r[PRW-1], prod_r, 1'b0} + NW'({1'b0, den_b_r});
  assign div_den   = {den_b_r, 1'b0};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j_r[AW-1:0];
    if (state_r == ST_SCAN) begin
      rd_en = issue_r;
    end else if ((state_r == ST_CHK) && !fin_r && (cnt_r != '0) && !bmode &&
                 (pt_r < cnt_r)) begin
      rd_en   = 1'b1;
      rd_addr = pt_r[AW-1:0];
    end
  end

  wmm_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[cnt_eff[AW-1:0]] <= q_item.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= sample_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= LEFT_RST;
      top_r    <= TOP_RST;
      right_r  <= RIGHT_RST;
      bottom_r <= BOTTOM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEFT:   left_r   <= cfg_wdata;
        REG_TOP:    top_r    <= cfg_wdata;
        REG_RIGHT:  right_r  <= cfg_wdata;
        REG_BOTTOM: bottom_r <= cfg_wdata;
        default:    left_r   <= left_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      op_r      <= OP_JF;
      cnt_r     <= '0;
      min_r     <= '0;
      max_r     <= '0;
      col_r     <= '0;
      jb_r      <= '0;
      pt_r      <= '0;
      phase_r   <= 1'b0;
      fin_r     <= 1'b0;
      issue_r   <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.first) begin
              cnt_r   <= '0;
              col_r   <= '0;
              jb_r    <= '0;
              pt_r    <= '0;
              phase_r <= 1'b0;
              fin_r   <= 1'b0;
            end
            if (q_item.kind == KIND_FETCH) begin
              state_r <= ST_CHK;
            end else if (mem_we) begin
              cnt_r <= cnt_eff + 1'b1;
              if (cnt_eff == '0) begin
                min_r <= q_item.sample;
                max_r <= (SAMPLE_W + 1)'(q_item.sample) + 1'b1;
              end else begin
                if (q_item.sample < min_r) min_r <= q_item.sample;
                if ((SAMPLE_W + 1)'(q_item.sample) > max_r) begin
                  max_r <= (SAMPLE_W + 1)'(q_item.sample);
                end
              end
            end
          end
        end
        ST_CHK: begin
          res_r <= '0;
          if (fin_r) begin
            state_r <= ST_IDLE;
          end else if (cnt_r == '0) begin
            res_r.done  <= 1'b1;
            res_r.empty <= 1'b1;
            fin_r       <= 1'b1;
            state_r     <= ST_EMIT;
          end else if (bmode) begin
            if ((c_x > w_x) || (jb_r >= cnt_r)) begin
              res_r.done  <= 1'b1;
              res_r.empty <= 1'b1;
              fin_r       <= 1'b1;
              state_r     <= ST_EMIT;
            end else if (!w_pos) begin
              // Without a positive width every bucket holds a single sample.
              if (cn1 >= cnt_r) begin
                res_r.done  <= 1'b1;
                res_r.empty <= 1'b1;
                fin_r       <= 1'b1;
                state_r     <= ST_EMIT;
              end else begin
                jf_r         <= cn1;
                j_r          <= jb_r;
                issue_r      <= 1'b1;
                scan_first_r <= 1'b1;
                state_r      <= ST_SCAN;
              end
            end else begin
              mul_a_r <= MA'(cn1);
              mul_b_r <= MB'(cnt_r);
              den_b_r <= BW'($unsigned(wd));
              op_r    <= OP_JF;
              state_r <= ST_MUL;
            end
          end else if (pt_r >= cnt_r) begin
            res_r.done  <= 1'b1;
            res_r.empty <= 1'b1;
            fin_r       <= 1'b1;
            state_r     <= ST_EMIT;
          end else begin
            state_r <= ST_PREAD;
          end
        end
        ST_PREAD: begin
          mul_a_r <= MA'(rdata_r) - MA'(min_r);
          mul_b_r <= MB'(dy);
          den_b_r <= rng_b;
          op_r    <= OP_PL;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_SCAN: begin
          if (issue_r) begin
            j_r <= j_r + 1'b1;
            if ((j_r + 1'b1) >= jf_r) issue_r <= 1'b0;
          end
          if (rd_vld_r) begin
            scan_first_r <= 1'b0;
            if (scan_first_r || (rdata_r < lo_r)) lo_r <= rdata_r;
            if (scan_first_r || (rdata_r > hi_r)) hi_r <= rdata_r;
          end
          if (!issue_r && !rd_vld_r) begin
            mul_a_r <= MA'(lo_r) - MA'(min_r);
            mul_b_r <= MB'(dy);
            den_b_r <= rng_b;
            op_r    <= OP_L1;
            state_r <= ST_MUL;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            unique case (op_r)
              OP_JF: begin
                if (div_q >= m_n) begin
                  res_r.done  <= 1'b1;
                  res_r.empty <= 1'b1;
                  fin_r       <= 1'b1;
                  state_r     <= ST_EMIT;
                end else begin
                  jf_r         <= CW'(div_q);
                  j_r          <= jb_r;
                  issue_r      <= 1'b1;
                  scan_first_r <= 1'b1;
                  state_r      <= ST_SCAN;
                end
              end
              OP_L1: begin
                l1_r <= q_l;
                if (!phase_r) begin
                  res_r.x   <= COORD_W'(16'(x0) + 16'(col_r));
                  res_r.y   <= COORD_W'(16'(ybase) - 16'(q_l));
                  res_r.pen <= 1'b0;
                  phase_r   <= 1'b1;
                  state_r   <= ST_EMIT;
                end else begin
                  mul_a_r <= MA'(hi_r) - MA'(min_r);
                  mul_b_r <= MB'(dy);
                  den_b_r <= rng_b;
                  op_r    <= OP_L2;
                  state_r <= ST_MUL;
                end
              end
              OP_L2: begin
                res_r.x   <= COORD_W'(16'(x0) + 16'(col_r));
                res_r.y   <= COORD_W'(16'(ybase) - 16'(l2));
                res_r.pen <= 1'b1;
                col_r     <= cn1;
                jb_r      <= jf_r;
                phase_r   <= 1'b0;
                // Look ahead: does the column after this one exist?
                if (cn_x > w_x) begin
                  res_r.done <= 1'b1;
                  fin_r      <= 1'b1;
                  state_r    <= ST_EMIT;
                end else if (!w_pos) begin
                  res_r.done <= (cn2 >= {1'b0, cnt_r});
                  fin_r      <= (cn2 >= {1'b0, cnt_r});
                  state_r    <= ST_EMIT;
                end else begin
                  mul_a_r <= MA'(cn2);
                  mul_b_r <= MB'(cnt_r);
                  den_b_r <= BW'($unsigned(wd));
                  op_r    <= OP_JN;
                  state_r <= ST_MUL;
                end
              end
              OP_JN: begin
                res_r.done <= (div_q >= m_n);
                fin_r      <= (div_q >= m_n);
                state_r    <= ST_EMIT;
              end
              OP_PL: begin
                l1_r <= q_l;
                if (cnt_r < CW'(2)) begin
                  res_r.x    <= COORD_W'(x0);
                  res_r.y    <= COORD_W'(16'(ybase) - 16'(q_l));
                  res_r.pen  <= (pt_r != '0);
                  res_r.done <= pt_last;
                  fin_r      <= pt_last;
                  pt_r       <= pt_r + 1'b1;
                  state_r    <= ST_EMIT;
                end else begin
                  mul_a_r <= MA'(pt_r);
                  mul_b_r <= MB'(wd);
                  den_b_r <= BW'(cnt_r - 1'b1);
                  op_r    <= OP_PX;
                  state_r <= ST_MUL;
                end
              end
              OP_PX: begin
                res_r.x    <= COORD_W'(16'(x0) + 16'(div_q));
                res_r.y    <= COORD_W'(16'(ybase) - 16'(l1_r));
                res_r.pen  <= (pt_r != '0);
                res_r.done <= pt_last;
                fin_r      <= pt_last;
                pt_r       <= pt_r + 1'b1;
                state_r    <= ST_EMIT;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * COORD_W){1'b0}}, out_r.y, out_r.x};
  assign out_tlast  = out_r.done;
  assign out_tuser  = {out_r.empty, out_r.pen};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("sample count beyond store depth");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.empty) |-> out_r.done) else $error("empty result not last");
  a_read_use: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_PREAD))
    else $error("sample read with no consumer");

endmodule
`default_nettype wire

/* hw/rtl/waveform_min_max_plotter_unit.sv */
// A load is stored when the back end pops it from the queue. A point fetch reads its sample
// from the one-read store, then multiplies and divides for the height and, given two or more
// samples, for x; a column fetch scans its bucket, then divides for the move or line ends and
// bucket bounds on the bit-serial divider (one quotient bit per cycle, 35 bits at default depth).
// Throughput: one load per cycle while the back end is idle; fetches are handled one at a time.
// Reset (rst_n, synchronous, active low) clears control state and presets the rectangle registers;
// the sample store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module waveform_min_max_plotter_unit #(
  parameter int MAX_SAMPLES = wmm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wmm_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  wire logic [wmm_pkg::REG_W-1:0]         cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [wmm_pkg::IN_DATA_W-1:0]     in_tdata,  // sample[15:0], first[16]
  input  wire logic                              in_tuser,  // cmd
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [wmm_pkg::OUT_DATA_W-1:0]         out_tdata, // x[13:0], y[27:14]
  output logic                                   out_tlast, // done_res
  output logic [wmm_pkg::OUT_USER_W-1:0]         out_tuser  // pen_down[0], empty_res[1]
);
  import wmm_pkg::*;

  logic      q_valid, q_pop;
  wmm_item_t q_item;

  wmm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wmm_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the min/max waveform plotter: stream stimulus and a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import wmm_pkg::*;

  localparam int PAUSE_CYCLES = 2500;
  localparam int HOLD_CYCLES  = 1500;

  // Predicts every drawing command and compares the returned stream against it.
  class plot_scoreboard;
    int unsigned left_edge, top_edge, right_edge, bottom_edge;
    int          samples[MAX_SAMPLES_DEF];
    int          n_samples, rec_min, rec_max;
    int          column, bucket_lo, point, phase;
    bit          finished;
    wmm_res_t    cmd_q[$];
    int          mismatches;

    function new();
      left_edge = LEFT_RST; top_edge = TOP_RST;
      right_edge = RIGHT_RST; bottom_edge = BOTTOM_RST;
      n_samples = 0; rec_min = 0; rec_max = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      column = 0; bucket_lo = 0; point = 0; phase = 0; finished = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
      case (idx)
        REG_LEFT:   left_edge = v;
        REG_TOP:    top_edge = v;
        REG_RIGHT:  right_edge = v;
        REG_BOTTOM: bottom_edge = v;
        default: ;
      endcase
    endfunction

    function longint rnd(longint a, longint b);
      return (2 * a + b) / (2 * b);
    endfunction

    function longint height(int v, longint dy);
      longint range;
      range = longint'(rec_max) - longint'(rec_min);
      if (range < 1) range = 1;
      return rnd((longint'(v) - longint'(rec_min)) * dy, range);
    endfunction

    function longint bound(longint k, longint w, longint m);
      if (w < 1) return k;
      return rnd(k * m, w);
    endfunction

    function bit column_ok(longint c, longint w, longint m);
      return c <= w && bound(c + 1, w, m) < m;
    endfunction

    function void push(longint x, longint y, bit pen, bit done, bit empty);
      wmm_res_t r;
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.pen = pen; r.done = done; r.empty = empty;
      cmd_q.push_back(r);
    endfunction

    function void draw_next();
      longint m, x0, y0, x1, dy, w, c, jf, l1, l2;
      int lo, hi;
      m = n_samples;
      x0 = longint'(left_edge) + 5;
      y0 = longint'(top_edge) + 5;
      x1 = longint'(right_edge) - 5;
      dy = (longint'(bottom_edge) - longint'(top_edge)) - 10;
      w = x1 - x0;
      if (finished) return;
      if (m == 0) begin
        finished = 1; push(0, 0, 0, 1, 1); return;
      end
      if (w < m) begin
        c = column;
        if (!column_ok(c, w, m) || bucket_lo >= m) begin
          finished = 1; push(0, 0, 0, 1, 1); return;
        end
        jf = bound(c + 1, w, m);
        lo = samples[bucket_lo];
        hi = lo;
        for (longint j = bucket_lo; j < jf; j++) begin
          if (samples[j] < lo) lo = samples[j];
          if (samples[j] > hi) hi = samples[j];
        end
        l1 = height(lo, dy);
        if (phase == 0) begin
          phase = 1; push(x0 + c, y0 + dy - l1, 0, 0, 0); return;
        end
        l2 = height(hi, dy);
        if (l2 <= l1) l2 = l1 + 1;
        phase = 0;
        column = c + 1;
        bucket_lo = jf;
        if (!column_ok(c + 1, w, m)) finished = 1;
        push(x0 + c, y0 + dy - l2, 1, finished, 0);
      end else begin
        if (point >= m) begin
          finished = 1; push(0, 0, 0, 1, 1); return;
        end
        l1 = height(samples[point], dy);
        c = (m < 2) ? x0 : x0 + rnd(longint'(point) * w, m - 1);
        push(c, y0 + dy - l1, point != 0, point == m - 1, 0);
        if (point == m - 1) finished = 1;
        point++;
      end
    endfunction

    // Called once per accepted input transaction.
    function void note_input(logic cmd, logic signed [SAMPLE_W-1:0] s, logic first);
      if (first) begin
        n_samples = 0; restart();
      end
      if (cmd == KIND_FETCH) begin
        draw_next();
        return;
      end
      if (n_samples >= MAX_SAMPLES_DEF) return;
      samples[n_samples] = s;
      if (n_samples == 0) begin
        rec_min = s; rec_max = int'(s) + 1;
      end else begin
        if (s < rec_min) rec_min = s;
        if (s > rec_max) rec_max = s;
      end
      n_samples++;
    endfunction

    function void check_result(wmm_res_t got);
      wmm_res_t want;
      if (cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = cmd_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d pen=%b done=%b empty=%b, got x=%0d y=%0d pen=%b done=%b empty=%b",
                   $signed(want.x), $signed(want.y), want.pen, want.done, want.empty,
                   $signed(got.x), $signed(got.y), got.pen, got.done, got.empty);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic [OUT_USER_W-1:0] out_tuser;

  plot_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;

  waveform_min_max_plotter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(logic cmd, logic signed [SAMPLE_W-1:0] s, logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'd0, first, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, s, first);
  endtask

  task automatic fetch(logic first = 1'b0);
    send_item(KIND_FETCH, 16'($urandom), first);
  endtask

  // Waits for the block to drain so that the registers may change.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_rect(int l, int t, int r, int b);
    write_reg(REG_LEFT, REG_W'(l)); write_reg(REG_TOP, REG_W'(t));
    write_reg(REG_RIGHT, REG_W'(r)); write_reg(REG_BOTTOM, REG_W'(b));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 7)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_record(int n);
    for (int i = 0; i < n; i++) send_item(KIND_LOAD, pick_sample(), i == 0);
  endtask

  // Fetches until the drawing ends, with occasional loads and restarts mixed in when noisy.
  task automatic draw_all(bit noisy);
    int guard;
    guard = 0;
    while (!sb.finished && guard < 400) begin
      if (noisy && $urandom_range(0, 30) == 0) send_item(KIND_LOAD, pick_sample(), 1'b0);
      else if (noisy && $urandom_range(0, 60) == 0) fetch(1'b1);
      else fetch();
      guard++;
    end
    repeat ($urandom_range(0, 2)) fetch();
  endtask

  task automatic random_rect();
    int l, t;
    l = $urandom_range(0, 3000);
    t = $urandom_range(0, 3000);
    case ($urandom_range(0, 4))
      0: set_rect(l, t, l + $urandom_range(0, 40), t + $urandom_range(0, 200));
      1: set_rect(l, t, l + $urandom_range(10, 400), t + $urandom_range(0, 1000));
      2: set_rect($urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
      3: set_rect(0, 0, 4095, 4095);
      default: set_rect(l, t + 50, l + $urandom_range(0, 60), t);
    endcase
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int gap;
    wmm_res_t r;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      r.x = out_tdata[13:0];
      r.y = out_tdata[27:14];
      r.pen = out_tuser[0];
      r.empty = out_tuser[1];
      r.done = out_tlast;
      sb.check_result(r);
    end
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int issued;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme samples in point mode, then fetches past the end.
    send_item(KIND_LOAD, 16'sh7FFF, 1'b1);
    send_item(KIND_LOAD, 16'sh8000, 1'b0);
    fetch(); fetch(); fetch();
    // Empty record, then a single-sample record.
    fetch(1'b1); fetch();
    send_item(KIND_LOAD, 16'sh0000, 1'b1);
    fetch(); fetch();
    // Load during a drawing keeps progress.
    load_record(3);
    fetch();
    send_item(KIND_LOAD, 16'sh1234, 1'b0);
    draw_all(0);
    settle();
    // Zero-width plot: bucket mode with one sample per column.
    set_rect(0, 0, 10, 4095);
    load_record(6);
    fetch(); fetch(); fetch();
    settle();
    // Registers change mid-drawing, leaving stale progress.
    set_rect(0, 0, 4095, 0);
    fetch(); fetch();
    settle();
    // Inverted rectangle: no column fits.
    set_rect(4095, 4095, 0, 0);
    load_record(4);
    fetch(); fetch();
    settle();

    // Long hold-off at the result side while fetches keep coming.
    set_rect(RIGHT_RST, TOP_RST, RIGHT_RST + 200, BOTTOM_RST);
    load_record(40);
    hold_req = 1;
    draw_all(0);
    settle();

    // Full record: one load past capacity, then a short drawing.
    no_idle = 1;
    set_rect(0, 0, 30, 100);
    load_record(MAX_SAMPLES_DEF + 1);
    for (int i = 0; i < 6; i++) fetch();
    no_idle = 0;
    settle();

    issued = 0;
    while (issued < 1050) begin
      random_rect();
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 5)) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 24);
        load_record(n);
        draw_all(1);
        issued += n + sb.column + sb.point + 3;
      end
      settle();
    end
    set_rect(LEFT_RST, TOP_RST, RIGHT_RST, BOTTOM_RST);
    settle();

    if (sb.mismatches == 0 && sb.cmd_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* waveform_min_max_plotter_unit.f */
hw/rtl/wmm_pkg.sv
hw/rtl/wmm_front.sv
hw/rtl/wmm_div.sv
hw/rtl/wmm_back.sv
hw/rtl/waveform_min_max_plotter_unit.sv
bench/testbench.sv
